>>> rtl/rbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types, widths and arithmetic helpers for the ray/box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIST_BITS  = 31;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;

  localparam logic signed [COORD_BITS-1:0] T_INF =
    {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] T_NEG =
    {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t inv_dir_x;
    coord_t inv_dir_y;
    coord_t inv_dir_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } ray_in_t;

  typedef struct packed {
    logic                 hit;
    logic [DIST_BITS-1:0] entry_distance;
  } ray_out_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Floor the product to FRAC_BITS fraction bits, saturate to COORD_BITS.
  function automatic coord_t fx_sat(input prod_t p);
    prod_t                         sh;
    logic [PROD_BITS-COORD_BITS:0] top;
    coord_t                        r;
    sh  = p >>> FRAC_BITS;
    top = sh[PROD_BITS-1:COORD_BITS-1];
    if ((&top) || !(|top)) begin
      r = sh[COORD_BITS-1:0];
    end else if (sh[PROD_BITS-1]) begin
      r = T_NEG;
    end else begin
      r = T_INF;
    end
    return r;
  endfunction

endpackage

>>> rtl/rbst_axis_slab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_axis_slab
// One axis of the slab test: corner distances, products with the inverse
// direction, floor and saturation, then ordering into near and far.
// Three register stages, each advanced by its own enable.
// ----------------------------------------------------------------------------
module rbst_axis_slab (
  input  logic               clk,
  input  rbst_pkg::stage_en_t en,
  input  rbst_pkg::coord_t   origin,
  input  rbst_pkg::coord_t   inv_dir,
  input  rbst_pkg::coord_t   box_min,
  input  rbst_pkg::coord_t   box_max,
  output rbst_pkg::coord_t   t_near,
  output rbst_pkg::coord_t   t_far
);
  import rbst_pkg::*;

  diff_t  d0;
  diff_t  d1;
  coord_t inv1;
  prod_t  p0;
  prod_t  p1;
  coord_t t0;
  coord_t t1;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d0   <= DIFF_BITS'(box_min) - DIFF_BITS'(origin);
      d1   <= DIFF_BITS'(box_max) - DIFF_BITS'(origin);
      inv1 <= inv_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p0 <= d0 * inv1;
      p1 <= d1 * inv1;
    end
  end

  always_comb begin
    t0 = fx_sat(p0);
    t1 = fx_sat(p1);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      t_near <= (t0 < t1) ? t0 : t1;
      t_far  <= (t0 < t1) ? t1 : t0;
    end
  end

endmodule

>>> rtl/ray_box_slab_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Ray versus axis-aligned box slab test in signed Q16.16, one result per ray.
//
//   channel  signals                     beat
//   in       in_valid/in_ready/in_data   ray origin, inverse dir, box corners
//   out      out_valid/out_ready/out_data hit flag, entry distance
//
// Five register stages: difference, multiply, saturate and order, reduce
// over axes, compare. One beat per cycle sustained while out_ready stays high.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and a stalled beat holds in place. Reset clears the valid bits.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbst_pkg::ray_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rbst_pkg::ray_out_t out_data
);
  import rbst_pkg::*;

  logic      v1, v2, v3, v4, v5;
  logic      en1, en2, en3, en4, en5;
  stage_en_t en;
  coord_t    near_x, near_y, near_z;
  coord_t    far_x, far_y, far_z;
  coord_t    near_all, far_all;
  coord_t    near_next, far_next;
  ray_out_t  res;

  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign en = '{s1: en1, s2: en2, s3: en3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  rbst_axis_slab u_axis_x (
    .clk(clk), .en(en),
    .origin(in_data.origin_x), .inv_dir(in_data.inv_dir_x),
    .box_min(in_data.box_min_x), .box_max(in_data.box_max_x),
    .t_near(near_x), .t_far(far_x)
  );

  rbst_axis_slab u_axis_y (
    .clk(clk), .en(en),
    .origin(in_data.origin_y), .inv_dir(in_data.inv_dir_y),
    .box_min(in_data.box_min_y), .box_max(in_data.box_max_y),
    .t_near(near_y), .t_far(far_y)
  );

  rbst_axis_slab u_axis_z (
    .clk(clk), .en(en),
    .origin(in_data.origin_z), .inv_dir(in_data.inv_dir_z),
    .box_min(in_data.box_min_z), .box_max(in_data.box_max_z),
    .t_near(near_z), .t_far(far_z)
  );

  // Far needs no clamp at T_INF: no saturated product exceeds it.
  always_comb begin
    near_next = '0;
    if (near_x > near_next) near_next = near_x;
    if (near_y > near_next) near_next = near_y;
    if (near_z > near_next) near_next = near_z;
    far_next = far_x;
    if (far_y < far_next) far_next = far_y;
    if (far_z < far_next) far_next = far_z;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      near_all <= near_next;
      far_all  <= far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      res.hit            <= (near_all <= far_all);
      res.entry_distance <= (near_all <= far_all) ? near_all[DIST_BITS-1:0]
                                                  : T_INF[DIST_BITS-1:0];
    end
  end

  assign out_valid = v5;
  assign out_data  = res;

endmodule

>>> rtl/rbst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks on the slab test unit, bound to the top level.
// ----------------------------------------------------------------------------
module rbst_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input rbst_pkg::ray_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input rbst_pkg::ray_out_t out_data
);
  import rbst_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready && (in_data.origin_x == in_data.origin_x);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_miss_inf: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.entry_distance == T_INF[DIST_BITS-1:0])
    else $error("miss without infinite distance");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    out_ready || !out_valid |-> in_ready)
    else $error("input blocked while output drains");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_fill_latency: assert property (@(posedge clk) disable iff (rst)
    in_beat && out_ready |=> ##3 out_ready |-> ##1 out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

>>> bench/tb_ray_box_slab_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_test_unit
// Self-checking bench for the ray/box slab test pipeline.
//
// Rays are pushed through the valid/ready input channel and every accepted
// beat is predicted in the bench: per-axis slab times are floored and
// clamped to Q16.16, near/far are reduced over the axes, and the hit flag
// and entry distance are queued. Each output beat is checked against the
// oldest queued result. A short directed set covers zero and extreme inverse
// directions, saturation, swapped and degenerate corners and rounding; the
// random part mostly aims rays at boxes, with extremes and raw noise mixed
// in. The random rays run in three phases of idle rates, the last with no idling.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test_unit;
  import rbst_pkg::*;

  localparam int     CYCLE_LIMIT = 200000;
  localparam int     DRAIN       = 20;
  localparam int     PHASE_RAYS  = 450;
  localparam coord_t ONE         = 32'sh0001_0000;

  class hit_scoreboard;
    ray_out_t expected_hits[$];
    int       errors = 0;

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function coord_t slab_time(coord_t corner, coord_t org, coord_t inv);
      logic signed [COORD_BITS+1:0]   gap;
      logic signed [2*COORD_BITS+3:0] prod;
      logic signed [2*COORD_BITS+3:0] floored;
      gap     = corner - org;
      prod    = gap * inv;
      floored = prod >>> FRAC_BITS;
      if (floored > T_INF) return T_INF;
      if (floored < T_NEG) return T_NEG;
      return floored[COORD_BITS-1:0];
    endfunction

    function ray_out_t predict_hit(ray_in_t r);
      coord_t   org[3], inv[3], bmin[3], bmax[3];
      coord_t   t0, t1, near, far, entry;
      ray_out_t res;
      org  = '{r.origin_x, r.origin_y, r.origin_z};
      inv  = '{r.inv_dir_x, r.inv_dir_y, r.inv_dir_z};
      bmin = '{r.box_min_x, r.box_min_y, r.box_min_z};
      bmax = '{r.box_max_x, r.box_max_y, r.box_max_z};
      near = '0;
      far  = T_INF;
      for (int a = 0; a < 3; a++) begin
        t0 = slab_time(bmin[a], org[a], inv[a]);
        t1 = slab_time(bmax[a], org[a], inv[a]);
        if ((t0 < t1 ? t0 : t1) > near) near = t0 < t1 ? t0 : t1;
        if ((t0 < t1 ? t1 : t0) < far) far = t0 < t1 ? t1 : t0;
      end
      res.hit            = near <= far;
      entry              = res.hit ? near : T_INF;
      res.entry_distance = entry[DIST_BITS-1:0];
      return res;
    endfunction

    function void note_ray(ray_in_t r);
      expected_hits.push_back(predict_hit(r));
    endfunction

    task check_result(input ray_out_t got);
      ray_out_t want;
      if (expected_hits.size() == 0) begin
        report("output beat with no ray pending");
        return;
      end
      want = expected_hits.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit got %b want %b", got.hit, want.hit));
      if (got.entry_distance !== want.entry_distance)
        report($sformatf("entry_distance got %h want %h",
                         got.entry_distance, want.entry_distance));
    endtask

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ray_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ray_out_t out_data;

  hit_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles      = 0;

  ray_box_slab_test_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_box_slab_test_unit verification failed");
      $finish;
    end
  end

  function automatic coord_t near_rand(int unsigned mag);
    int v;
    v = int'($urandom_range(2 * mag)) - int'(mag);
    return coord_t'(v);
  endfunction

  function automatic coord_t corner_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return T_INF;
      2:       return T_NEG;
      3:       return 32'sd1;
      4:       return -32'sd1;
      5:       return ONE;
      6:       return -ONE;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic ray_in_t uniform_ray(coord_t o, coord_t i, coord_t lo, coord_t hi);
    ray_in_t r;
    r.origin_x  = o;  r.origin_y  = o;  r.origin_z  = o;
    r.inv_dir_x = i;  r.inv_dir_y = i;  r.inv_dir_z = i;
    r.box_min_x = lo; r.box_min_y = lo; r.box_min_z = lo;
    r.box_max_x = hi; r.box_max_y = hi; r.box_max_z = hi;
    return r;
  endfunction

  function automatic ray_in_t random_ray();
    ray_in_t     r;
    coord_t      org[3], inv[3], lo[3], hi[3], c, tmp;
    int unsigned half;
    longint      dir, q;
    int          mode;
    mode = $urandom_range(99);
    for (int a = 0; a < 3; a++) begin
      if (mode < 60) begin
        c      = near_rand(100 << 16);
        half   = $urandom_range(1, 16 << 16);
        org[a] = near_rand(200 << 16);
        lo[a]  = c - coord_t'(half);
        hi[a]  = c + coord_t'(half);
        dir    = longint'(c) - longint'(org[a]) + longint'(near_rand(4 << 16));
        if (dir == 0) begin
          inv[a] = '0;
        end else begin
          q = (longint'(1) <<< 32) / dir;
          if (q > longint'(T_INF)) q = longint'(T_INF);
          if (q < longint'(T_NEG)) q = longint'(T_NEG);
          inv[a] = coord_t'(q);
        end
        if ($urandom_range(15) == 0) inv[a] = corner_value();
        if ($urandom_range(9) == 0) begin
          tmp   = lo[a];
          lo[a] = hi[a];
          hi[a] = tmp;
        end
      end else if (mode < 75) begin
        org[a] = corner_value();
        inv[a] = corner_value();
        lo[a]  = corner_value();
        hi[a]  = corner_value();
      end else if (mode < 85) begin
        org[a] = near_rand(1 << 20);
        inv[a] = ($urandom_range(2) == 0) ? coord_t'(0) : near_rand(1 << 20);
        lo[a]  = near_rand(1 << 20);
        hi[a]  = near_rand(1 << 20);
      end else begin
        org[a] = coord_t'($urandom);
        inv[a] = coord_t'($urandom);
        lo[a]  = coord_t'($urandom);
        hi[a]  = coord_t'($urandom);
      end
    end
    r.origin_x  = org[0]; r.origin_y  = org[1]; r.origin_z  = org[2];
    r.inv_dir_x = inv[0]; r.inv_dir_y = inv[1]; r.inv_dir_z = inv[2];
    r.box_min_x = lo[0];  r.box_min_y = lo[1];  r.box_min_z = lo[2];
    r.box_max_x = hi[0];  r.box_max_y = hi[1];  r.box_max_z = hi[2];
    return r;
  endfunction

  task automatic send_ray(input ray_in_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_ray(r);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (count) send_ray(random_ray());
  endtask

  initial begin
    ray_in_t r;
    tx_idle_pct = 37;
    rx_idle_pct <= 66;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_ray(uniform_ray('0, '0, '0, '0));
    send_ray(uniform_ray('0, ONE, ONE, 2 * ONE));
    send_ray(uniform_ray('0, ONE, -2 * ONE, -ONE));
    send_ray(uniform_ray('0, -ONE, -2 * ONE, -ONE));
    send_ray(uniform_ray('0, ONE, ONE, ONE));
    send_ray(uniform_ray('0, ONE, 2 * ONE, ONE));
    r = uniform_ray('0, ONE, ONE, 2 * ONE);
    r.inv_dir_y = '0;
    r.origin_y  = 5 * ONE;
    send_ray(r);
    send_ray(uniform_ray(ONE, T_INF, ONE, 3 * ONE));
    send_ray(uniform_ray(ONE, T_NEG, ONE, 3 * ONE));
    send_ray(uniform_ray('0, T_INF, 1000 * ONE, 2000 * ONE));
    send_ray(uniform_ray('0, T_NEG, 1000 * ONE, 2000 * ONE));
    send_ray(uniform_ray(T_INF, T_INF, T_INF, T_INF));
    send_ray(uniform_ray(T_NEG, T_NEG, T_NEG, T_NEG));
    send_ray(uniform_ray(T_NEG, T_INF, T_INF, T_INF));
    send_ray(uniform_ray(T_INF, T_NEG, T_NEG, T_NEG));
    send_ray(uniform_ray(T_INF, T_NEG, T_NEG, T_INF));
    send_ray(uniform_ray(-32'sd1, 32'sd1, '0, 32'sd1));
    send_ray(uniform_ray(32'sd1, 32'sd1, '0, '0));
    send_ray(uniform_ray('0, -32'sd1, 32'sd1, 32'sd1));
    send_ray(uniform_ray(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA));
    send_ray(uniform_ray(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));

    run_phase(37, 66, PHASE_RAYS);
    run_phase(66, 37, PHASE_RAYS);
    run_phase(0, 0, PHASE_RAYS);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ray_box_slab_test_unit verification clean");
    end else begin
      $display("ray_box_slab_test_unit verification failed");
    end
    $finish;
  end

endmodule
